/* rtl/i2cbs_pkg.sv */
package i2cbs_pkg;

   localparam int BITS_PER_BYTE = 8;
   localparam int SLOT_IDX_W    = 5;
   localparam int DELAY_W       = 16;

   localparam logic [1:0] CMD_START    = 2'd0;
   localparam logic [1:0] CMD_STOP     = 2'd1;
   localparam logic [1:0] CMD_WRITE    = 2'd2;
   localparam logic [1:0] CMD_WAIT_ACK = 2'd3;

   typedef struct packed {
      logic [1:0]               req_type;
      logic [BITS_PER_BYTE-1:0] tx_byte;
      logic                     sda_sample;
   } req_beat_type;

   typedef struct packed {
      logic scl_out;
      logic sda_out;
      logic sda_is_input;
      logic ack_missing;
      logic last_slot;
   } rsp_beat_type;

endpackage

/* rtl/i2cbs_timer.sv */
module i2cbs_timer (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         load,
   input  logic [i2cbs_pkg::DELAY_W-1:0] delay,
   output logic                         done
);

   logic [i2cbs_pkg::DELAY_W-1:0] count_ff;
   logic [i2cbs_pkg::DELAY_W-1:0] count_in;

   always_comb begin
      count_in = count_ff;
      if (load) begin
         count_in = delay;
      end else if (count_ff > i2cbs_pkg::DELAY_W'(1)) begin
         count_in = count_ff - i2cbs_pkg::DELAY_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign done = !load && (count_ff <= i2cbs_pkg::DELAY_W'(1));

endmodule

/* rtl/i2cbs_seq.sv */
module i2cbs_seq (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  i2cbs_pkg::req_beat_type       req_data,
   input  logic [i2cbs_pkg::DELAY_W-1:0] slot_delay,
   output logic                          slot_valid,
   input  logic                          slot_take,
   output i2cbs_pkg::rsp_beat_type       slot_data
);

   typedef enum logic [1:0] {ST_IDLE, ST_EMIT, ST_HOLD} state_type;

   state_type                                state_ff;
   logic [1:0]                               cmd_ff;
   logic [i2cbs_pkg::BITS_PER_BYTE-1:0]      shift_ff;
   logic [i2cbs_pkg::BITS_PER_BYTE-1:0]      shift_in;
   logic                                     sample_ff;
   logic [i2cbs_pkg::SLOT_IDX_W-1:0]         idx_ff;
   logic                                     scl_ff;
   logic                                     sda_ff;
   logic                                     rel_ff;
   logic                                     scl_in;
   logic                                     sda_in;
   logic                                     rel_in;
   logic                                     last_ff;
   logic                                     last_in;
   logic                                     ack_in;
   logic                                     timer_load;
   logic                                     timer_done;

   i2cbs_timer u_timer (
      .clock (clock),
      .reset (reset),
      .load  (timer_load),
      .delay (slot_delay),
      .done  (timer_done)
   );

   always_comb begin
      scl_in   = scl_ff;
      sda_in   = sda_ff;
      rel_in   = rel_ff;
      shift_in = shift_ff;
      last_in  = 1'b0;
      ack_in   = 1'b0;
      unique case (cmd_ff)
         i2cbs_pkg::CMD_START: begin
            if (idx_ff == 5'd0) begin
               rel_in = 1'b0;
               sda_in = 1'b1;
            end
            if (idx_ff == 5'd1) begin
               scl_in = 1'b1;
            end
            if (idx_ff == 5'd3) begin
               sda_in = 1'b0;
            end
            if (idx_ff == 5'd5) begin
               scl_in  = 1'b0;
               last_in = 1'b1;
            end
         end
         i2cbs_pkg::CMD_STOP: begin
            if (idx_ff == 5'd0) begin
               rel_in = 1'b0;
               sda_in = 1'b0;
            end
            if (idx_ff == 5'd1) begin
               scl_in = 1'b1;
            end
            if (idx_ff == 5'd2) begin
               sda_in  = 1'b1;
               last_in = 1'b1;
            end
         end
         i2cbs_pkg::CMD_WRITE: begin
            rel_in = 1'b0;
            unique case (idx_ff[1:0])
               2'd0: begin
                  if (idx_ff[4:2] != 3'd0) begin
                     scl_in = 1'b0;
                  end
               end
               2'd1: begin
                  sda_in   = shift_ff[i2cbs_pkg::BITS_PER_BYTE-1];
                  shift_in = {shift_ff[i2cbs_pkg::BITS_PER_BYTE-2:0], 1'b0};
               end
               2'd2: begin
                  scl_in = 1'b1;
               end
               2'd3: begin
                  last_in = (idx_ff[4:2] == 3'(i2cbs_pkg::BITS_PER_BYTE - 1));
               end
            endcase
         end
         i2cbs_pkg::CMD_WAIT_ACK: begin
            rel_in = 1'b1;
            if (idx_ff == 5'd1) begin
               scl_in = 1'b1;
            end
            if (idx_ff == 5'd2) begin
               scl_in  = 1'b0;
               last_in = 1'b1;
               ack_in  = sample_ff;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
         scl_ff   <= 1'b1;
         sda_ff   <= 1'b1;
         rel_ff   <= 1'b0;
         last_ff  <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  cmd_ff    <= req_data.req_type;
                  shift_ff  <= req_data.tx_byte;
                  sample_ff <= req_data.sda_sample;
                  idx_ff    <= '0;
                  state_ff  <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               if (slot_take) begin
                  // drop SCL once the last bit of a byte has been clocked
                  scl_ff   <= scl_in & ~(last_in & (cmd_ff == i2cbs_pkg::CMD_WRITE));
                  sda_ff   <= sda_in;
                  rel_ff   <= rel_in;
                  shift_ff <= shift_in;
                  last_ff  <= last_in;
                  idx_ff   <= idx_ff + 5'd1;
                  state_ff <= ST_HOLD;
               end
            end
            ST_HOLD: begin
               if (timer_done) begin
                  state_ff <= last_ff ? ST_IDLE : ST_EMIT;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_ready  = (state_ff == ST_IDLE);
   assign slot_valid = (state_ff == ST_EMIT);
   assign timer_load = slot_valid && slot_take;

   assign slot_data.scl_out      = scl_in;
   assign slot_data.sda_out      = rel_in | sda_in;
   assign slot_data.sda_is_input = rel_in;
   assign slot_data.ack_missing  = ack_in;
   assign slot_data.last_slot    = last_in;

endmodule

/* rtl/i2c_master_bit_sequencer.sv */
// I2C master bit sequencer: one command beat (start, stop, write byte, wait acknowledge)
// produces a run of pin-state beats (6, 3, 32 and 3 beats) carrying SCL, SDA, SDA release
// and, on the last wait-acknowledge beat, ack_missing. Line levels carry over between
// commands. Each slot is issued into the output register once the result side can take
// it, and is then held by the slot timer, loaded from slot_delay, before the next slot;
// a stalled result side delays the issue. A new command is taken once the previous run
// has finished its last hold.
module i2c_master_bit_sequencer (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  i2cbs_pkg::req_beat_type       req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output i2cbs_pkg::rsp_beat_type       rsp_data,
   input  logic                          csr_wr_en,
   input  logic [i2cbs_pkg::DELAY_W-1:0] csr_wr_data
);

   logic [i2cbs_pkg::DELAY_W-1:0] slot_delay_ff;
   logic                          rsp_valid_ff;
   logic                          rsp_valid_in;
   i2cbs_pkg::rsp_beat_type       rsp_data_ff;
   logic                          slot_valid;
   logic                          slot_take;
   i2cbs_pkg::rsp_beat_type       slot_data;

   i2cbs_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .slot_delay (slot_delay_ff),
      .slot_valid (slot_valid),
      .slot_take  (slot_take),
      .slot_data  (slot_data)
   );

   assign slot_take = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (slot_take) begin
         rsp_valid_in = slot_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_delay_ff <= i2cbs_pkg::DELAY_W'(1);
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            slot_delay_ff <= csr_wr_data;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (slot_take && slot_valid) begin
         rsp_data_ff <= slot_data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* rtl/i2cbs_checker.sv */
module i2cbs_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input i2cbs_pkg::req_beat_type       req_data,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input i2cbs_pkg::rsp_beat_type       rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result beat changed while stalled");

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_data))
      else $error("command beat dropped or changed while waiting");

   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("command taken while a run is under way");

   a_ack_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.ack_missing |-> rsp_data.last_slot)
      else $error("ack_missing outside the last slot");

   a_release_high: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.sda_is_input |-> rsp_data.sda_out)
      else $error("released SDA shown low");

endmodule

bind i2c_master_bit_sequencer i2cbs_checker u_checker (.*);

/* tb/i2c_master_bit_sequencer_test.sv */
`timescale 1ns / 100ps

module i2c_master_bit_sequencer_test;

   typedef struct packed {
      logic [1:0]                          cmd;
      logic [i2cbs_pkg::BITS_PER_BYTE-1:0] byte_val;
      logic                                sample;
      logic [2:0]                          lit_len;
      logic [29:0]                         lit_run;
   } bus_row_type;

   localparam int DIR_ROWS = 21;
   localparam int HOLD_OFF = 300;

   logic                            clock = 1'b0;
   logic                            reset;
   logic                            req_valid;
   logic                            req_ready;
   i2cbs_pkg::req_beat_type         req_data;
   logic                            rsp_valid;
   logic                            rsp_ready;
   i2cbs_pkg::rsp_beat_type         rsp_data;
   logic                            csr_wr_en;
   logic [i2cbs_pkg::DELAY_W-1:0]   csr_wr_data;

   i2cbs_pkg::rsp_beat_type         pin_slot_q [$];
   i2cbs_pkg::rsp_beat_type         bus_run [$];
   logic                            line_scl = 1'b1;
   logic                            line_sda = 1'b1;
   logic                            sda_let_go = 1'b0;
   int                              cur_hold = 1;
   int                              send_idle_pct = 18;
   int                              recv_idle_pct = 59;
   bit                              rsp_hold_due = 1'b0;
   int                              mismatch_count = 0;

   i2c_master_bit_sequencer uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #10ns clock = ~clock;

   task automatic flag_mismatch(input string what, input logic [4:0] got_bits,
                                input logic [4:0] want_bits);
      $display("%0t: %s mismatch, got %b expected %b", $realtime, what, got_bits, want_bits);
      mismatch_count++;
   endtask

   task automatic put_pin_slot(input logic ack, input logic fin);
      i2cbs_pkg::rsp_beat_type s;
      s.scl_out      = line_scl;
      s.sda_out      = sda_let_go ? 1'b1 : line_sda;
      s.sda_is_input = sda_let_go;
      s.ack_missing  = ack;
      s.last_slot    = fin;
      bus_run.push_back(s);
   endtask

   task automatic sequence_bus_command(input i2cbs_pkg::req_beat_type beat);
      logic [i2cbs_pkg::BITS_PER_BYTE-1:0] shift;
      bus_run.delete();
      shift = beat.tx_byte;
      unique case (beat.req_type)
         i2cbs_pkg::CMD_START: begin
            sda_let_go = 1'b0;
            line_sda   = 1'b1;
            put_pin_slot(1'b0, 1'b0);
            line_scl = 1'b1;
            put_pin_slot(1'b0, 1'b0);
            put_pin_slot(1'b0, 1'b0);
            line_sda = 1'b0;
            put_pin_slot(1'b0, 1'b0);
            put_pin_slot(1'b0, 1'b0);
            line_scl = 1'b0;
            put_pin_slot(1'b0, 1'b1);
         end
         i2cbs_pkg::CMD_STOP: begin
            sda_let_go = 1'b0;
            line_sda   = 1'b0;
            put_pin_slot(1'b0, 1'b0);
            line_scl = 1'b1;
            put_pin_slot(1'b0, 1'b0);
            line_sda = 1'b1;
            put_pin_slot(1'b0, 1'b1);
         end
         i2cbs_pkg::CMD_WRITE: begin
            sda_let_go = 1'b0;
            for (int b = 0; b < i2cbs_pkg::BITS_PER_BYTE; b++) begin
               put_pin_slot(1'b0, 1'b0);
               line_sda = shift[i2cbs_pkg::BITS_PER_BYTE-1];
               shift    = shift << 1;
               put_pin_slot(1'b0, 1'b0);
               line_scl = 1'b1;
               put_pin_slot(1'b0, 1'b0);
               put_pin_slot(1'b0, b == i2cbs_pkg::BITS_PER_BYTE - 1);
               line_scl = 1'b0;
            end
         end
         i2cbs_pkg::CMD_WAIT_ACK: begin
            sda_let_go = 1'b1;
            put_pin_slot(1'b0, 1'b0);
            line_scl = 1'b1;
            put_pin_slot(1'b0, 1'b0);
            line_scl = 1'b0;
            put_pin_slot(beat.sda_sample, 1'b1);
         end
      endcase
   endtask

   function automatic bus_row_type any_row(input logic [1:0] cmd);
      bus_row_type r;
      r.cmd      = cmd;
      r.byte_val = i2cbs_pkg::BITS_PER_BYTE'($urandom_range(0, 255));
      r.sample   = 1'($urandom_range(0, 1));
      r.lit_len  = '0;
      r.lit_run  = '0;
      return r;
   endfunction

   task automatic offer_row(input bus_row_type r);
      i2cbs_pkg::req_beat_type beat;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      beat.req_type   = r.cmd;
      beat.tx_byte    = r.byte_val;
      beat.sda_sample = r.sample;
      req_data  <= beat;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      sequence_bus_command(beat);
      if (r.lit_len == 0) begin
         foreach (bus_run[j]) pin_slot_q.push_back(bus_run[j]);
      end else begin
         for (int j = 0; j < r.lit_len; j++) pin_slot_q.push_back(r.lit_run[29 - 5*j -: 5]);
      end
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (pin_slot_q.size() != 0) @(posedge clock);
   endtask

   task automatic settle_and_write(input logic [i2cbs_pkg::DELAY_W-1:0] value);
      drain_results();
      repeat (cur_hold + 4) @(posedge clock);
      csr_wr_data <= value;
      csr_wr_en   <= 1'b1;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cur_hold = (value == 0) ? 1 : int'(value);
   endtask

   task automatic random_traffic(input int target);
      int done;
      int n_bytes;
      done = 0;
      while (done < target) begin
         if ($urandom_range(0, 4) == 0) begin
            offer_row(any_row(2'($urandom_range(0, 3))));
            done++;
         end else begin
            n_bytes = int'($urandom_range(1, 3));
            offer_row(any_row(i2cbs_pkg::CMD_START));
            repeat (n_bytes) begin
               offer_row(any_row(i2cbs_pkg::CMD_WRITE));
               offer_row(any_row(i2cbs_pkg::CMD_WAIT_ACK));
            end
            offer_row(any_row(i2cbs_pkg::CMD_STOP));
            done += 2 + 2 * n_bytes;
         end
      end
   endtask

   always @(posedge clock) begin : slot_check
      i2cbs_pkg::rsp_beat_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pin_slot_q.size() == 0) begin
            flag_mismatch("unexpected beat", rsp_data, '0);
         end else begin
            want = pin_slot_q.pop_front();
            if (rsp_data.scl_out !== want.scl_out)
               flag_mismatch("scl_out", rsp_data, want);
            if (rsp_data.sda_out !== want.sda_out)
               flag_mismatch("sda_out", rsp_data, want);
            if (rsp_data.sda_is_input !== want.sda_is_input)
               flag_mismatch("sda_is_input", rsp_data, want);
            if (rsp_data.ack_missing !== want.ack_missing)
               flag_mismatch("ack_missing", rsp_data, want);
            if (rsp_data.last_slot !== want.last_slot)
               flag_mismatch("last_slot", rsp_data, want);
         end
      end
   end

   initial begin
      int hold_left;
      hold_left = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_due) begin
            rsp_hold_due = 1'b0;
            hold_left    = HOLD_OFF;
         end
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   initial begin
      #50ms;
      $display("i2c_master_bit_sequencer regression: fail");
      $finish;
   end

   initial begin
      bus_row_type dir_rows [DIR_ROWS];
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_data    <= '0;
      csr_wr_en   <= 1'b0;
      csr_wr_data <= '0;
      dir_rows = '{
         {i2cbs_pkg::CMD_START,    8'h00, 1'b0, 3'd6,
          {5'b11000, 5'b11000, 5'b11000, 5'b10000, 5'b10000, 5'b00001}},
         {i2cbs_pkg::CMD_WRITE,    8'hFF, 1'b0, 3'd0, 30'd0},
         {i2cbs_pkg::CMD_WAIT_ACK, 8'h00, 1'b0, 3'd3,
          {5'b01100, 5'b11100, 5'b01101, 15'd0}},
         {i2cbs_pkg::CMD_WRITE,    8'h00, 1'b0, 3'd0, 30'd0},
         {i2cbs_pkg::CMD_WAIT_ACK, 8'h00, 1'b1, 3'd3,
          {5'b01100, 5'b11100, 5'b01111, 15'd0}},
         {i2cbs_pkg::CMD_STOP,     8'h00, 1'b0, 3'd3,
          {5'b00000, 5'b10000, 5'b11001, 15'd0}},
         {i2cbs_pkg::CMD_STOP,     8'h00, 1'b0, 3'd3,
          {5'b10000, 5'b10000, 5'b11001, 15'd0}},
         {i2cbs_pkg::CMD_WAIT_ACK, 8'h00, 1'b1, 3'd3,
          {5'b11100, 5'b11100, 5'b01111, 15'd0}},
         {i2cbs_pkg::CMD_START,    8'h00, 1'b0, 3'd6,
          {5'b01000, 5'b11000, 5'b11000, 5'b10000, 5'b10000, 5'b00001}},
         {i2cbs_pkg::CMD_WRITE,    8'hA5, 1'b0, 3'd0, 30'd0},
         {i2cbs_pkg::CMD_WRITE,    8'h5A, 1'b0, 3'd0, 30'd0},
         {i2cbs_pkg::CMD_WRITE,    8'h80, 1'b0, 3'd0, 30'd0},
         {i2cbs_pkg::CMD_WRITE,    8'h01, 1'b0, 3'd0, 30'd0},
         {i2cbs_pkg::CMD_WAIT_ACK, 8'h00, 1'b0, 3'd3,
          {5'b01100, 5'b11100, 5'b01101, 15'd0}},
         {i2cbs_pkg::CMD_WRITE,    8'h00, 1'b0, 3'd0, 30'd0},
         {i2cbs_pkg::CMD_START,    8'h00, 1'b0, 3'd0, 30'd0},
         {i2cbs_pkg::CMD_START,    8'hFF, 1'b1, 3'd0, 30'd0},
         {i2cbs_pkg::CMD_WAIT_ACK, 8'hFF, 1'b0, 3'd0, 30'd0},
         {i2cbs_pkg::CMD_STOP,     8'hFF, 1'b1, 3'd0, 30'd0},
         {i2cbs_pkg::CMD_WRITE,    8'hFF, 1'b1, 3'd0, 30'd0},
         {i2cbs_pkg::CMD_WAIT_ACK, 8'h00, 1'b1, 3'd0, 30'd0}
      };
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIR_ROWS; i++) offer_row(dir_rows[i]);

      // zero delay, long result hold-off so the block backs up
      settle_and_write('0);
      rsp_hold_due = 1'b1;
      random_traffic(120);

      settle_and_write(i2cbs_pkg::DELAY_W'(3));
      send_idle_pct = 59;
      recv_idle_pct = 18;
      random_traffic(60);
      drain_results();
      random_traffic(60);

      settle_and_write(i2cbs_pkg::DELAY_W'($urandom_range(4, 9)));
      send_idle_pct = 0;
      recv_idle_pct = 0;
      random_traffic(120);

      settle_and_write('1);
      offer_row(any_row(i2cbs_pkg::CMD_STOP));
      drain_results();
      repeat (cur_hold + 8) @(posedge clock);

      if (mismatch_count == 0 && pin_slot_q.size() == 0) begin
         $display("i2c_master_bit_sequencer regression: pass");
      end else begin
         $display("i2c_master_bit_sequencer regression: fail");
      end
      $finish;
   end

endmodule
